[rtl/cdth_pkg.sv]
// ----------------------------------------------------------------------------
// cdth_pkg: shared types and constants for contact_debounce_tap_hold
// Field widths, register indexes, reset values and the per-contact result.
// ----------------------------------------------------------------------------
package cdth_pkg;

  // field widths fixed by the stream format
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned PIN_W       = 3;
  localparam int unsigned GEST_W      = 2;
  localparam int unsigned GESTS_W     = PIN_W * GEST_W;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 1;

  // default number of contact lanes
  localparam int unsigned CONTACT_COUNT_DEF = 3;

  // register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd35;
  localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd1600;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD     = 1'b1;

  // gesture codes
  typedef enum logic [GEST_W-1:0] {
    GEST_NONE = 2'd0,
    GEST_TAP  = 2'd1,
    GEST_HOLD = 2'd2
  } gesture_t;

  // what one lane reports for one poll
  typedef struct packed {
    logic     closed;
    gesture_t gesture;
  } lane_res_t;

endpackage

[rtl/cdth_lane.sv]
// ----------------------------------------------------------------------------
// cdth_lane: debounce and tap/hold detection for one contact
// Keeps the settle and hold timestamps of one contact and updates them on
// every accepted poll, giving the settled level and the gesture of that poll.
// ----------------------------------------------------------------------------
module cdth_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  poll_req,
  input  logic [cdth_pkg::TIME_W-1:0]           now_ms,
  input  logic                                  raw_closed,
  input  logic [cdth_pkg::CFG_W-1:0]            debounce_time,
  input  logic [cdth_pkg::CFG_W-1:0]            hold_time,
  output cdth_pkg::lane_res_t                   res
);
  import cdth_pkg::*;

  logic              settled_level;
  logic              previous_raw;
  logic [TIME_W-1:0] change_time;
  logic [TIME_W-1:0] close_time;
  logic              hold_reported;

  logic              settled_level_next;
  logic [TIME_W-1:0] change_time_next;
  logic [TIME_W-1:0] close_time_next;
  logic              hold_reported_next;

  logic              raw_changed;
  logic [TIME_W-1:0] steady_ms;
  logic [TIME_W-1:0] closed_ms;
  logic              accept;
  logic              accept_close;
  logic              hold_base;
  logic              tap_hit;
  logic              hold_hit;

  // settle timer: a raw change restarts it at zero
  always_comb begin
    raw_changed      = raw_closed != previous_raw;
    change_time_next = raw_changed ? now_ms : change_time;
    steady_ms        = raw_changed ? '0 : (now_ms - change_time);
    accept           = (raw_closed != settled_level) &&
                       (steady_ms >= {{(TIME_W-CFG_W){1'b0}}, debounce_time});
    accept_close     = accept && raw_closed;
  end

  // hold timer and gesture decisions
  always_comb begin
    settled_level_next = accept ? raw_closed : settled_level;
    close_time_next    = accept_close ? now_ms : close_time;
    closed_ms          = accept_close ? '0 : (now_ms - close_time);
    hold_base          = accept_close ? 1'b0 : hold_reported;
    tap_hit            = accept && !raw_closed && !hold_reported;
    hold_hit           = settled_level_next && !hold_base &&
                         (closed_ms >= {{(TIME_W-CFG_W){1'b0}}, hold_time});
    hold_reported_next = hold_hit | hold_base;
  end

  // poll result
  always_comb begin
    res.closed = settled_level_next;
    if (hold_hit) begin
      res.gesture = GEST_HOLD;
    end else if (tap_hit) begin
      res.gesture = GEST_TAP;
    end else begin
      res.gesture = GEST_NONE;
    end
  end

  // contact state, advanced once per accepted poll
  always_ff @(posedge clk) begin
    if (rst) begin
      settled_level <= 1'b0;
      previous_raw  <= 1'b0;
      change_time   <= '0;
      close_time    <= '0;
      hold_reported <= 1'b0;
    end else if (poll_req) begin
      settled_level <= settled_level_next;
      previous_raw  <= raw_closed;
      change_time   <= change_time_next;
      close_time    <= close_time_next;
      hold_reported <= hold_reported_next;
    end
  end

  // a hold is only seen on a closed contact
  a_hold_closed: assert property (@(posedge clk) disable iff (rst)
    (poll_req && res.gesture == GEST_HOLD) |-> res.closed)
    else $error("hold reported on an open contact");

  // a tap only comes with the release
  a_tap_open: assert property (@(posedge clk) disable iff (rst)
    (poll_req && res.gesture == GEST_TAP) |=> !settled_level && !hold_reported)
    else $error("tap reported without a release");

  // after a hold no second hold until a new close
  a_hold_once: assert property (@(posedge clk) disable iff (rst)
    (poll_req && hold_hit) |=> hold_reported)
    else $error("hold flag not kept after a hold");

endmodule

[rtl/cdth_merge.sv]
// ----------------------------------------------------------------------------
// cdth_merge: gathers the lane results into one result request
// Packs the settled levels and gestures of all lanes and holds them in an
// output register backed by a skid register.
// ----------------------------------------------------------------------------
module cdth_merge #(
  parameter int unsigned CONTACT_COUNT = cdth_pkg::CONTACT_COUNT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   poll_req,
  input  cdth_pkg::lane_res_t [CONTACT_COUNT-1:0] lane_res,
  output logic                                   poll_ready,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // m_tdata fields from bit 0: debounced_contacts[2:0], gestures[8:3], zeros
  output logic [cdth_pkg::OUT_DATA_W-1:0]        m_tdata
);
  import cdth_pkg::*;

  localparam int unsigned RES_W = PIN_W + GESTS_W;

  logic [PIN_W-1:0]   closed_bits;
  logic [GESTS_W-1:0] gest_bits;
  logic [RES_W-1:0]   new_res;

  logic [RES_W-1:0]   out_res;
  logic               out_valid;
  logic [RES_W-1:0]   skid_res;
  logic               skid_valid;

  // pack the lanes that fit the output fields
  for (genvar i = 0; i < PIN_W; i++) begin : g_pack
    if (i < CONTACT_COUNT) begin : g_lane
      assign closed_bits[i]                  = lane_res[i].closed;
      assign gest_bits[i*GEST_W +: GEST_W]   = lane_res[i].gesture;
    end else begin : g_none
      assign closed_bits[i]                  = 1'b0;
      assign gest_bits[i*GEST_W +: GEST_W]   = GEST_NONE;
    end
  end

  assign new_res = {gest_bits, closed_bits};

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= poll_req;
      end
    end else if (poll_req) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_res <= skid_valid ? skid_res : new_res;
    end else if (poll_req) begin
      skid_res <= new_res;
    end
  end

  assign poll_ready = !skid_valid;
  assign m_tvalid   = out_valid;
  assign m_tdata    = {{(OUT_DATA_W-RES_W){1'b0}}, out_res};

  // skid holds a request only behind a waiting output
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid full with an empty output register");

  // a request into a stalled full output lands in the skid
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready && poll_req) |=> skid_valid)
    else $error("request lost on a stalled output");

  // a drained skid moves forward into the output register
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_tready) |=> out_valid && !skid_valid)
    else $error("skid not drained on output request");

endmodule

[rtl/contact_debounce_tap_hold.sv]
// ----------------------------------------------------------------------------
// contact_debounce_tap_hold: debounced contacts with tap and hold gestures
// One lane per contact runs the settle and hold timers; a merge stage packs
// the lane results behind an output register and skid register.
// ----------------------------------------------------------------------------
// Each poll request carries a millisecond timestamp and the raw pin levels
// (low = closed) and yields exactly one result request, held in the output
// or skid register, with the settled contacts and a tap or hold code per
// contact. A poll is taken every cycle: all lanes update in that cycle,
// each with two 32-bit subtract-and-compare paths, and the two-entry output
// buffer keeps taking polls until both entries wait on a stalled output.
// Timing is in the caller's milliseconds, differences wrap modulo 2^32;
// debounce_time and hold_time take effect on the next poll after a write.
module contact_debounce_tap_hold #(
  parameter int unsigned CONTACT_COUNT = cdth_pkg::CONTACT_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration writes
  input  logic                                 cfg_wr_en,
  input  logic [cdth_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cdth_pkg::CFG_W-1:0]           cfg_data,
  // poll requests
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // s_tdata fields from bit 0: now_ms[31:0], pin_levels[34:32], zeros
  input  logic [cdth_pkg::IN_DATA_W-1:0]       s_tdata,
  // result requests
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata fields from bit 0: debounced_contacts[2:0], gestures[8:3], zeros
  output logic [cdth_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import cdth_pkg::*;

  logic [CFG_W-1:0]                 debounce_time;
  logic [CFG_W-1:0]                 hold_time;
  logic                             poll_req;
  logic                             poll_ready;
  logic [TIME_W-1:0]                now_ms;
  logic [PIN_W-1:0]                 pin_levels;
  lane_res_t [CONTACT_COUNT-1:0]    lane_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= DEBOUNCE_RESET;
      hold_time     <= HOLD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce_time <= cfg_data;
        CFG_HOLD:     hold_time     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input unpacking
  assign now_ms     = s_tdata[TIME_W-1:0];
  assign pin_levels = s_tdata[TIME_W +: PIN_W];
  assign s_tready   = poll_ready;
  assign poll_req   = s_tvalid && poll_ready;

  // one lane per contact; contacts without a pin read as open
  for (genvar k = 0; k < CONTACT_COUNT; k++) begin : g_lane
    logic raw_closed;
    if (k < PIN_W) begin : g_pin
      assign raw_closed = !pin_levels[k];
    end else begin : g_nopin
      assign raw_closed = 1'b0;
    end

    cdth_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .poll_req      (poll_req),
      .now_ms        (now_ms),
      .raw_closed    (raw_closed),
      .debounce_time (debounce_time),
      .hold_time     (hold_time),
      .res           (lane_res[k])
    );
  end

  // merge and output buffering
  cdth_merge #(
    .CONTACT_COUNT (CONTACT_COUNT)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .poll_req   (poll_req),
    .lane_res   (lane_res),
    .poll_ready (poll_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
